[rtl/rbsr_pkg.sv]
package rbsr_pkg;

    localparam int LATENCY_DEPTH_DEF = 64;
    localparam int MAX_BUSES_DEF     = 32;

    localparam logic       IDEAL_MODE_RST = 1'b0;
    localparam logic [4:0] BUS_WIDTH_RST  = 5'd2;
    localparam logic [4:0] BANK_COUNT_RST = 5'd4;

    typedef enum logic [1:0] {
        CFG_IDEAL_MODE = 2'd0,
        CFG_BUS_WIDTH  = 2'd1,
        CFG_BANK_COUNT = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_TICK    = 1'b0,
        CMD_REQUEST = 1'b1
    } command_t;

    typedef struct packed {
        logic       command;
        logic [5:0] latency;
        logic [1:0] dest_count;
        logic [3:0] first_bank;
        logic [3:0] second_bank;
        logic       lock_ok;
    } req_t;

    typedef struct packed {
        logic       accepted;
        logic [4:0] free_slots;
    } res_t;

    typedef struct packed {
        logic       ideal_mode;
        logic [4:0] bus_width;
        logic [4:0] bank_count;
    } cfg_t;

endpackage

[rtl/rbsr_bus_array.sv]
module rbsr_bus_array #(
    parameter int LATENCY_DEPTH = 64,
    parameter int MAX_BUSES     = 32
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        advance,
    input  logic                                        tick,
    input  logic [MAX_BUSES-1:0]                        set_lat,
    input  logic [MAX_BUSES-1:0]                        set_lat1,
    input  logic [LATENCY_DEPTH-1:0]                    lat_oh,
    input  logic [LATENCY_DEPTH-1:0]                    lat1_oh,
    output logic [MAX_BUSES-1:0][LATENCY_DEPTH-1:0]     slots
);

    logic [MAX_BUSES-1:0][LATENCY_DEPTH-1:0] slots_reg;
    logic [MAX_BUSES-1:0][LATENCY_DEPTH-1:0] slots_next;

    always_comb begin
        for (int b = 0; b < MAX_BUSES; b++) begin
            if (tick) begin
                slots_next[b] = slots_reg[b] >> 1;
            end else begin
                slots_next[b] = slots_reg[b]
                              | (set_lat[b]  ? lat_oh  : '0)
                              | (set_lat1[b] ? lat1_oh : '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= '0;
        end else if (advance) begin
            slots_reg <= slots_next;
        end
    end

    assign slots = slots_reg;

endmodule

[rtl/rbsr_alloc.sv]
module rbsr_alloc #(
    parameter int LATENCY_DEPTH = 64,
    parameter int MAX_BUSES     = 32
) (
    input  rbsr_pkg::cfg_t                              cfg,
    input  rbsr_pkg::req_t                              req,
    input  logic [MAX_BUSES-1:0][LATENCY_DEPTH-1:0]     slots,
    output logic                                        tick,
    output logic [MAX_BUSES-1:0]                        set_lat,
    output logic [MAX_BUSES-1:0]                        set_lat1,
    output logic [LATENCY_DEPTH-1:0]                    lat_oh,
    output logic [LATENCY_DEPTH-1:0]                    lat1_oh,
    output rbsr_pkg::res_t                              res
);

    import rbsr_pkg::*;

    localparam logic [MAX_BUSES-1:0] ONE = {{(MAX_BUSES-1){1'b0}}, 1'b1};

    logic                 lat_ok;
    logic                 lat1_ok;
    logic [5:0]           active_n;
    logic [MAX_BUSES-1:0] active;
    logic [MAX_BUSES-1:0] spare;
    logic [MAX_BUSES-1:0] col;
    logic [MAX_BUSES-1:0] col1;
    logic [MAX_BUSES-1:0] oh1;
    logic [MAX_BUSES-1:0] oh2;
    logic [5:0]           used;
    logic [5:0]           used1;
    logic [4:0]           fs;
    logic [4:0]           fs1;
    logic [MAX_BUSES-1:0] free_gen;
    logic [MAX_BUSES-1:0] pick_a;
    logic [MAX_BUSES-1:0] rest;
    logic [MAX_BUSES-1:0] pick_b;
    logic [MAX_BUSES-1:0] free_spare;
    logic [MAX_BUSES-1:0] pick_spare;
    logic                 bad1;
    logic                 bad2;
    logic                 taken1;
    logic                 taken2;
    logic                 taken2_next;
    logic                 ok;

    always_comb begin
        lat_ok  = int'(req.latency) < LATENCY_DEPTH;
        lat1_ok = int'(req.latency) + 1 < LATENCY_DEPTH;
        for (int d = 0; d < LATENCY_DEPTH; d++) begin
            lat_oh[d]  = int'(req.latency) == d;
            lat1_oh[d] = int'(req.latency) + 1 == d;
        end

        active_n = {1'b0, cfg.bus_width} + (cfg.ideal_mode ? {1'b0, cfg.bank_count} : 6'd0);
        if (int'(active_n) > MAX_BUSES) begin
            active_n = 6'(MAX_BUSES);
        end

        for (int b = 0; b < MAX_BUSES; b++) begin
            active[b] = b < int'(active_n);
            spare[b]  = b >= int'(cfg.bank_count);
            col[b]    = |(slots[b] & lat_oh);
            col1[b]   = |(slots[b] & lat1_oh);
            oh1[b]    = int'(req.first_bank) == b;
            oh2[b]    = int'(req.second_bank) == b;
        end

        // free slot counts at lat_oh and lat1_oh, floored at zero
        used  = 6'($countones(col & active));
        used1 = 6'($countones(col1 & active));
        fs    = (used  >= {1'b0, cfg.bus_width}) ? 5'd0 : cfg.bus_width - used[4:0];
        fs1   = (used1 >= {1'b0, cfg.bus_width}) ? 5'd0 : cfg.bus_width - used1[4:0];

        // lowest two free general buses
        free_gen = ~col & active;
        pick_a   = free_gen & (~free_gen + ONE);
        rest     = free_gen & ~pick_a;
        pick_b   = rest & (~rest + ONE);

        free_spare = ~col & active & spare;
        pick_spare = free_spare & (~free_spare + ONE);

        bad1 = ({1'b0, req.first_bank} >= cfg.bank_count)
            || ({2'b0, req.first_bank} >= active_n);
        bad2 = ({1'b0, req.second_bank} >= cfg.bank_count)
            || ({2'b0, req.second_bank} >= active_n);
        taken1      = |(col & oh1);
        taken2      = |(col & oh2);
        taken2_next = |(col1 & oh2);

        tick     = req.command == CMD_TICK;
        ok       = 1'b0;
        set_lat  = '0;
        set_lat1 = '0;

        if (!tick && lat_ok) begin
            if (!cfg.ideal_mode) begin
                if (req.dest_count[1]) begin
                    ok = req.lock_ok && fs >= 5'd2;
                    set_lat = pick_a | pick_b;
                end else begin
                    ok = req.lock_ok && fs != 5'd0;
                    set_lat = pick_a;
                end
            end else if (fs != 5'd0) begin
                if (req.dest_count == 2'd0) begin
                    ok = 1'b1;
                    set_lat = pick_spare;
                end else if (!bad1 && !taken1) begin
                    set_lat = oh1;
                    if (!req.dest_count[1]) begin
                        ok = 1'b1;
                    end else if (!bad2) begin
                        if (req.first_bank == req.second_bank) begin
                            // same bank: second write reserves the lat1_oh slot
                            ok = lat1_ok && !taken2_next && fs1 != 5'd0;
                            set_lat1 = oh2;
                        end else begin
                            ok = !taken2 && fs >= 5'd2;
                            set_lat = oh1 | oh2;
                        end
                    end
                end
            end
        end

        if (!ok) begin
            set_lat  = '0;
            set_lat1 = '0;
        end

        res.accepted   = ok;
        res.free_slots = (!tick && lat_ok) ? fs : 5'd0;
    end

endmodule

[rtl/result_bus_slot_reservation.sv]
// Writeback result bus slot reservation. Each result bus owns a shift
// register of LATENCY_DEPTH bits, one bit per latency, a set bit meaning the bus is busy.
// A tick beat shifts every bus right by one; a request beat checks free
// slots at its latency and, when granted, reserves bus slots (general mode:
// lowest free buses; ideal mode: the destination banks' own buses, or a spare
// bus for a request with no destinations). Every beat yields one result beat
// carrying the grant flag and the free slot count seen before reserving.
// One beat per cycle is sustained while m_ready stays high: a beat waits in
// the input register, the bus array is read and updated as it leaves, and the
// result lands in the output register, so the next beat already sees the
// updated reservations.
// Write the configuration only while no beat is in flight.
module result_bus_slot_reservation #(
    parameter int LATENCY_DEPTH = rbsr_pkg::LATENCY_DEPTH_DEF,
    parameter int MAX_BUSES     = rbsr_pkg::MAX_BUSES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [4:0]      cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  rbsr_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rbsr_pkg::res_t  m_data
);

    import rbsr_pkg::*;

    cfg_t cfg_reg;

    // input register
    logic in_valid_reg;
    req_t in_data_reg;

    // output register
    logic out_valid_reg;
    res_t out_data_reg;

    logic advance;
    logic tick;
    logic [MAX_BUSES-1:0]                    set_lat;
    logic [MAX_BUSES-1:0]                    set_lat1;
    logic [LATENCY_DEPTH-1:0]                lat_oh;
    logic [LATENCY_DEPTH-1:0]                lat1_oh;
    logic [MAX_BUSES-1:0][LATENCY_DEPTH-1:0] slots;
    res_t                                    res;

    // move the held beat to the output whenever the output slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ideal_mode <= IDEAL_MODE_RST;
            cfg_reg.bus_width  <= BUS_WIDTH_RST;
            cfg_reg.bank_count <= BANK_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDEAL_MODE: cfg_reg.ideal_mode <= cfg_wdata[0];
                CFG_BUS_WIDTH:  cfg_reg.bus_width  <= cfg_wdata;
                CFG_BANK_COUNT: cfg_reg.bank_count <= cfg_wdata;
                default:        ; // drop writes to unused indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= res;
        end
    end

    rbsr_alloc #(
        .LATENCY_DEPTH (LATENCY_DEPTH),
        .MAX_BUSES     (MAX_BUSES)
    ) u_alloc (
        .cfg      (cfg_reg),
        .req      (in_data_reg),
        .slots    (slots),
        .tick     (tick),
        .set_lat  (set_lat),
        .set_lat1 (set_lat1),
        .lat_oh   (lat_oh),
        .lat1_oh  (lat1_oh),
        .res      (res)
    );

    // hold the reservations; update only when a beat leaves the input register
    rbsr_bus_array #(
        .LATENCY_DEPTH (LATENCY_DEPTH),
        .MAX_BUSES     (MAX_BUSES)
    ) u_bus_array (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .tick     (tick),
        .set_lat  (set_lat),
        .set_lat1 (set_lat1),
        .lat_oh   (lat_oh),
        .lat1_oh  (lat1_oh),
        .slots    (slots)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[tb/sv/result_bus_slot_reservation_tb.sv]
`timescale 1ns / 1ps

module result_bus_slot_reservation_tb;

    import rbsr_pkg::*;

    // Generous bound: the slowest profile stalls often, and the bound sits far
    // above what a run of a few hundred beats needs.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int BUS_COUNT    = MAX_BUSES_DEF;
    localparam int DEPTH        = LATENCY_DEPTH_DEF;
    localparam int PHASE_BEATS  = 50;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = CFG_IDEAL_MODE;
    logic [4:0] cfg_wdata = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    req_t       s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    res_t       m_data;

    // Predictor state: one reservation bit vector per bus plus the settings.
    logic [DEPTH-1:0] bus_busy [BUS_COUNT];
    logic             model_ideal;
    logic [4:0]       model_width;
    logic [4:0]       model_banks;

    // Grants still to come back from the block, oldest first.
    res_t grant_q [$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    result_bus_slot_reservation i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Buses in play: the general ones, plus one per bank in ideal mode,
    // capped at the number of physical buses.
    function automatic int unsigned active_bus_count();
        int unsigned n;
        n = model_width + (model_ideal ? model_banks : 5'd0);
        if (n > BUS_COUNT) n = BUS_COUNT;
        return n;
    endfunction

    // General slots left at a latency, floored at zero.
    function automatic int unsigned free_at(int unsigned lat);
        int unsigned used;
        int unsigned n;
        used = 0;
        n = active_bus_count();
        for (int unsigned b = 0; b < n; b++) begin
            if (bus_busy[b][lat]) used++;
        end
        return (used >= model_width) ? 0 : model_width - used;
    endfunction

    function automatic bit grant_general(int unsigned lat, int unsigned dests, bit lock,
                                         int unsigned fs);
        int unsigned need;
        int unsigned n;
        need = (dests == 0) ? 1 : dests;
        n = active_bus_count();
        if (fs < need || !lock) return 1'b0;
        // Claim the lowest free buses first.
        for (int unsigned b = 0; b < n && need > 0; b++) begin
            if (!bus_busy[b][lat]) begin
                bus_busy[b][lat] = 1'b1;
                need--;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit grant_ideal(int unsigned lat, int unsigned dests, int unsigned b1,
                                       int unsigned b2, int unsigned fs);
        int unsigned n;
        n = active_bus_count();
        if (fs == 0) return 1'b0;
        if (dests == 0) begin
            // Take the first free spare bus; with none free, still grant.
            for (int unsigned b = model_banks; b < n; b++) begin
                if (!bus_busy[b][lat]) begin
                    bus_busy[b][lat] = 1'b1;
                    break;
                end
            end
            return 1'b1;
        end
        if (b1 >= model_banks || b1 >= n) return 1'b0;
        if (bus_busy[b1][lat]) return 1'b0;
        if (dests >= 2) begin
            if (b2 >= model_banks || b2 >= n) return 1'b0;
            if (b1 == b2) begin
                // Same bank: the second write takes the next bit up.
                if (lat + 1 >= DEPTH) return 1'b0;
                if (bus_busy[b2][lat + 1] || free_at(lat + 1) == 0) return 1'b0;
                bus_busy[b2][lat + 1] = 1'b1;
            end else begin
                if (bus_busy[b2][lat] || fs <= 1) return 1'b0;
                bus_busy[b2][lat] = 1'b1;
            end
        end
        bus_busy[b1][lat] = 1'b1;
        return 1'b1;
    endfunction

    // Work out the result of one beat and advance the predictor state.
    function automatic res_t grant_request(req_t r);
        res_t        res;
        int unsigned dests;
        int unsigned fs;
        res = '0;
        dests = r.dest_count;
        if (dests > 2) dests = 2;
        if (r.command == CMD_TICK) begin
            for (int b = 0; b < BUS_COUNT; b++) bus_busy[b] = bus_busy[b] >> 1;
            return res;
        end
        // A 6-bit latency always indexes inside the DEPTH-bit reservation vectors.
        fs = free_at(r.latency);
        if (model_ideal)
            res.accepted = grant_ideal(r.latency, dests, r.first_bank, r.second_bank, fs);
        else
            res.accepted = grant_general(r.latency, dests, r.lock_ok, fs);
        res.free_slots = fs[4:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers and checker
    // ------------------------------------------------------------------

    function automatic req_t make_req(logic cmd, int unsigned lat, int unsigned dests,
                                      int unsigned b1, int unsigned b2, logic lock);
        req_t r;
        r.command     = cmd;
        r.latency     = lat[5:0];
        r.dest_count  = dests[1:0];
        r.first_bank  = b1[3:0];
        r.second_bank = b2[3:0];
        r.lock_ok     = lock;
        return r;
    endfunction

    // Send one beat; predict it at the edge where it is taken.
    task automatic issue_beat(req_t r);
        res_t pred;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = grant_request(r);
        grant_q = {grant_q, pred};
    endtask

    // Drop valid and wait until every grant has come back, plus a margin
    // for the input and output registers.
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers on consecutive edges; only call when idle.
    task automatic program_buses(logic ideal, int unsigned width, int unsigned banks);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDEAL_MODE;
        cfg_wdata <= {4'b0, ideal};
        @(posedge aclk);
        cfg_index <= CFG_BUS_WIDTH;
        cfg_wdata <= width[4:0];
        @(posedge aclk);
        cfg_index <= CFG_BANK_COUNT;
        cfg_wdata <= banks[4:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_ideal = ideal;
        model_width = width[4:0];
        model_banks = banks[4:0];
    endtask

    // Mostly well-formed requests clustered at short latencies so buses
    // collide; the rest ticks, stray banks and missing cache locks.
    function automatic req_t make_random_beat();
        req_t r;
        r = '0;
        r.first_bank  = 4'($urandom_range(0, 15));
        r.second_bank = 4'($urandom_range(0, 15));
        r.latency     = 6'($urandom_range(0, 62));
        r.dest_count  = 2'($urandom_range(0, 3));
        r.lock_ok     = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 25) begin
            r.command = CMD_TICK;
            return r;
        end
        r.command = CMD_REQUEST;
        if ($urandom_range(0, 3) != 0) r.latency = 6'($urandom_range(0, 7));
        r.dest_count = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        if (model_ideal && $urandom_range(0, 9) != 0) begin
            r.first_bank  = 4'($urandom_range(0, model_banks - 1));
            r.second_bank = ($urandom_range(0, 2) == 0) ? r.first_bank
                                                        : 4'($urandom_range(0, model_banks - 1));
        end
        r.lock_ok = ($urandom_range(0, 9) != 0);
        return r;
    endfunction

    // Receiver stall pattern, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        res_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (grant_q.size() == 0) begin
                $error("unexpected result beat: accepted %0d free_slots %0d",
                       m_data.accepted, m_data.free_slots);
                error_count++;
            end else begin
                exp = grant_q.pop_front();
                if (m_data.accepted !== exp.accepted) begin
                    $error("accepted: expected %0d, actual %0d", exp.accepted, m_data.accepted);
                    error_count++;
                end
                if (m_data.free_slots !== exp.free_slots) begin
                    $error("free_slots: expected %0d, actual %0d",
                           exp.free_slots, m_data.free_slots);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL result_bus_slot_reservation");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (general, two buses, four banks), no writes yet.
    task automatic test_reset_settings();
        issue_beat(make_req(CMD_REQUEST, 0, 1, 0, 0, 1'b1));
        issue_beat(make_req(CMD_REQUEST, 0, 2, 0, 0, 1'b1));   // one slot left, need two
        issue_beat(make_req(CMD_REQUEST, 0, 1, 0, 0, 1'b0));   // no cache lock
        issue_beat(make_req(CMD_REQUEST, 62, 2, 0, 0, 1'b1));
        issue_beat(make_req(CMD_REQUEST, 62, 0, 0, 0, 1'b1));  // latency full
        issue_beat(make_req(CMD_TICK, 0, 0, 0, 0, 1'b0));
        issue_beat(make_req(CMD_REQUEST, 61, 3, 0, 0, 1'b1));  // shifted down, count three
        issue_beat(make_req(CMD_REQUEST, 63, 1, 0, 0, 1'b1));  // top bit of the register
        settle_pipeline();
    endtask

    task automatic test_general_extremes();
        program_buses(1'b0, 16, 4);
        issue_beat(make_req(CMD_REQUEST, 5, 2, 15, 15, 1'b1));
        settle_pipeline();
        // Zero bus width: nothing can ever be granted.
        program_buses(1'b0, 0, 4);
        issue_beat(make_req(CMD_REQUEST, 0, 0, 0, 0, 1'b1));
        settle_pipeline();
    endtask

    task automatic test_ideal_banks();
        program_buses(1'b1, 2, 4);
        issue_beat(make_req(CMD_REQUEST, 3, 0, 0, 0, 1'b0));   // spare bus
        issue_beat(make_req(CMD_REQUEST, 4, 1, 2, 0, 1'b0));
        issue_beat(make_req(CMD_REQUEST, 4, 1, 2, 0, 1'b1));   // bank conflict
        issue_beat(make_req(CMD_REQUEST, 5, 2, 0, 1, 1'b1));
        issue_beat(make_req(CMD_REQUEST, 4, 2, 0, 1, 1'b1));   // only one slot left
        issue_beat(make_req(CMD_REQUEST, 6, 2, 3, 3, 1'b1));   // same bank, next latency
        issue_beat(make_req(CMD_REQUEST, 63, 2, 3, 3, 1'b1));  // same bank off the end
        issue_beat(make_req(CMD_REQUEST, 8, 1, 4, 0, 1'b1));   // bank out of range
        issue_beat(make_req(CMD_REQUEST, 9, 3, 1, 1, 1'b1));
        settle_pipeline();
        program_buses(1'b1, 16, 16);
        issue_beat(make_req(CMD_REQUEST, 62, 2, 15, 0, 1'b1));
        issue_beat(make_req(CMD_REQUEST, 62, 0, 0, 0, 1'b1));
        settle_pipeline();
        program_buses(1'b1, 1, 1);
        issue_beat(make_req(CMD_REQUEST, 0, 1, 0, 0, 1'b1));
        issue_beat(make_req(CMD_REQUEST, 1, 2, 0, 0, 1'b1));
        issue_beat(make_req(CMD_TICK, 0, 0, 0, 0, 1'b1));
        settle_pipeline();
    endtask

    // Three idle profiles, three settings each; the first four settings are
    // the extremes, the rest random.
    task automatic test_random_traffic();
        int unsigned tx_pct [3] = '{11, 79, 0};
        int unsigned rx_pct [3] = '{79, 11, 0};
        logic        ext_ideal [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
        int unsigned ext_width [4] = '{16, 16, 1, 1};
        int unsigned ext_banks [4] = '{16, 16, 1, 1};
        int          phase;
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = tx_pct[p];
            rx_idle_pct = rx_pct[p];
            for (int k = 0; k < 3; k++) begin
                phase = p * 3 + k;
                if (phase < 4)
                    program_buses(ext_ideal[phase], ext_width[phase], ext_banks[phase]);
                else
                    program_buses(1'($urandom_range(0, 1)), $urandom_range(1, 16),
                                  $urandom_range(1, 16));
                repeat (PHASE_BEATS) issue_beat(make_random_beat());
                settle_pipeline();
            end
        end
    endtask

    initial begin
        for (int b = 0; b < BUS_COUNT; b++) bus_busy[b] = '0;
        model_ideal = IDEAL_MODE_RST;
        model_width = BUS_WIDTH_RST;
        model_banks = BANK_COUNT_RST;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 11;
        rx_idle_pct = 79;
        test_reset_settings();
        test_general_extremes();
        test_ideal_banks();
        test_random_traffic();

        // Give any stray beat time to show up before the verdict.
        repeat (20) @(posedge aclk);
        if (grant_q.size() != 0) begin
            $error("%0d result beats never arrived", grant_q.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASS result_bus_slot_reservation");
        end else begin
            $display("FAIL result_bus_slot_reservation");
        end
        $finish;
    end

endmodule
